// File: src/impulse_collision_resolver_assert.svh
// Assertion macros for the collision resolver checker.
`ifndef IMPULSE_COLLISION_RESOLVER_ASSERT_SVH
`define IMPULSE_COLLISION_RESOLVER_ASSERT_SVH

// Implication checked at every rising clock edge except during reset.
`define ICR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ICR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/icr_pkg.sv
package icr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW = 32;
  localparam int DIV_STAGES = 32;
  localparam int IMP_STAGE = DIV_STAGES + 4;
  localparam int PIPE_DEPTH = IMP_STAGE + 3;

  typedef enum logic [1:0] {
    OUT_SKIP   = 2'd0,
    OUT_SHIFT  = 2'd1,
    OUT_IMPULSE = 2'd2
  } outcome_t;

  function automatic logic signed [QW-1:0] sat32(input logic signed [95:0] v);
    logic signed [95:0] mx;
    logic signed [95:0] mn;
    mx = 96'sh7FFFFFFF;
    mn = -96'sh80000000;
    if (v > mx) begin
      return 32'sh7FFFFFFF;
    end else if (v < mn) begin
      return 32'sh80000000;
    end
    return v[QW-1:0];
  endfunction

  function automatic logic signed [95:0] fsh(input logic signed [95:0] v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic logic signed [QW-1:0] qmul_f(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat32(fsh(96'(p)));
  endfunction

endpackage

// File: src/icr_div.sv
module icr_div import icr_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quo
);

  // Restoring divider, two quotient bits per stage.
  logic [63:0] rem [0:DIV_STAGES-1];
  logic [63:0] q   [0:DIV_STAGES-1];
  logic [63:0] d   [0:DIV_STAGES-1];

  function automatic logic [128:0] step2(input logic [63:0] r, input logic [63:0] qq,
                                          input logic [63:0] dd);
    logic [64:0] rr;
    logic [63:0] qn;
    int i;
    rr = {1'b0, r};
    qn = qq;
    for (i = 0; i < 2; i++) begin
      rr = {rr[63:0], qn[63]};
      qn = {qn[62:0], 1'b0};
      if (rr >= {1'b0, dd}) begin
        rr = rr - {1'b0, dd};
        qn[0] = 1'b1;
      end
    end
    return {rr, qn};
  endfunction

  always_ff @(posedge clk) begin
    logic [128:0] t;
    if (en) begin
      t = step2(64'd0, num, den);
      rem[0] <= t[127:64];
      q[0] <= t[63:0];
      d[0] <= den;
      for (int s = 1; s < DIV_STAGES; s++) begin
        t = step2(rem[s-1], q[s-1], d[s-1]);
        rem[s] <= t[127:64];
        q[s] <= t[63:0];
        d[s] <= d[s-1];
      end
    end
  end

  assign quo = q[DIV_STAGES-1];

endmodule

// File: src/impulse_collision_resolver.sv
// Impulse collision resolver: one 2D contact per word, one word per cycle sustained while the output is not stalled.
// Four stages form the relative normal speed and the impulse
// numerator, 32 pipelined quotient stages (two bits each) form the impulse magnitude
// and the mass ratios, and three stages apply the impulse and the overlap correction.
// A stall freezes the whole pipeline; the input accepts whenever the output register
// is free or moving.
module impulse_collision_resolver import icr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [30:0] mass_a,
  input  logic [30:0] mass_b,
  input  logic [30:0] inv_mass_a,
  input  logic [30:0] inv_mass_b,
  input  logic [63:0] vel_a,
  input  logic [63:0] vel_b,
  input  logic [63:0] contact_normal,
  input  logic signed [31:0] penetration,
  input  logic [16:0] restitution_a,
  input  logic [16:0] restitution_b,
  input  logic [1:0]  solid_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] new_vel_a,
  output logic [63:0] new_vel_b,
  output logic [63:0] shift_a,
  output logic [63:0] shift_b,
  output logic [1:0]  outcome
);

  typedef struct packed {
    logic [30:0] ma;
    logic [30:0] mb;
    logic [30:0] ima;
    logic [30:0] imb;
    logic signed [31:0] vax, vay, vbx, vby, nx, ny, pen;
    logic signed [31:0] rvx, rvy;
    logic [16:0] e;
    logic signed [63:0] p1, p2;
    logic signed [31:0] sp;
    logic res;
    logic imp;
    logic dnz;
    logic tot_nz;
    logic signed [31:0] j, ix, iy, corx, cory;
    logic [31:0] rat_a, rat_b;
    logic signed [31:0] dax, day, dbx, dby;
  } st_t;

  logic [30:0] thr;
  logic adv;
  logic [PIPE_DEPTH-1:0] vld;
  st_t s [0:PIPE_DEPTH-1];
  logic [63:0] num0, den0, man0, mbn0, tot0;
  logic [63:0] den1, tot1;
  logic [63:0] jq, raq, rbq;

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    st_t t;
    logic signed [95:0] lo, spd, pa, pb;
    if (adv) begin
      // Stage 0: capture, relative velocity.
      t = '0;
      t.ma = mass_a;
      t.mb = mass_b;
      t.ima = inv_mass_a;
      t.imb = inv_mass_b;
      t.vax = vel_a[31:0];
      t.vay = vel_a[63:32];
      t.vbx = vel_b[31:0];
      t.vby = vel_b[63:32];
      t.nx = contact_normal[31:0];
      t.ny = contact_normal[63:32];
      t.pen = penetration;
      t.res = (33'(signed'(penetration)) > $signed({2'b0, thr})) && solid_flags == 2'b11;
      t.tot_nz = (32'(mass_a) + 32'(mass_b)) != 32'd0;
      t.dnz = (32'(inv_mass_a) + 32'(inv_mass_b)) != 32'd0;
      t.rvx = sat32(96'(signed'(vel_b[31:0])) - 96'(signed'(vel_a[31:0])));
      t.rvy = sat32(96'(signed'(vel_b[63:32])) - 96'(signed'(vel_a[63:32])));
      t.e = restitution_a < restitution_b ? restitution_a : restitution_b;
      s[0] <= t;

      // Stage 1: normal products.
      t = s[0];
      t.p1 = 64'(t.rvx) * 64'(t.nx);
      t.p2 = 64'(t.rvy) * 64'(t.ny);
      s[1] <= t;

      // Stage 2: normal speed.
      t = s[1];
      lo = 96'(t.p1[FRAC_BITS-1:0]) + 96'(t.p2[FRAC_BITS-1:0]);
      spd = fsh(96'(t.p1)) + fsh(96'(t.p2)) + fsh(lo);
      t.sp = sat32(spd);
      t.imp = t.sp[QW-1] && t.dnz;
      s[2] <= t;

      // Stage 3: quotient operands.
      t = s[2];
      num0 <= ((64'd1 << FRAC_BITS) + 64'(t.e)) * 64'(-33'(t.sp));
      den0 <= 64'(t.ima) + 64'(t.imb);
      tot0 <= 64'(t.ma) + 64'(t.mb);
      man0 <= 64'(t.ma) << FRAC_BITS;
      mbn0 <= 64'(t.mb) << FRAC_BITS;
      s[3] <= t;

      for (int k = 4; k < IMP_STAGE; k++) begin
        s[k] <= s[k-1];
      end

      // Impulse magnitude and corrections.
      t = s[IMP_STAGE-1];
      t.j = sat32(96'(jq));
      t.corx = qmul_f(t.nx, t.pen);
      t.cory = qmul_f(t.ny, t.pen);
      t.rat_a = raq[31:0];
      t.rat_b = rbq[31:0];
      s[IMP_STAGE] <= t;

      // Impulse vector, shifts.
      t = s[IMP_STAGE];
      t.ix = qmul_f(t.nx, t.j);
      t.iy = qmul_f(t.ny, t.j);
      pa = 96'(t.corx) * 96'($signed({1'b0, t.rat_a}));
      pb = 96'(t.cory) * 96'($signed({1'b0, t.rat_a}));
      t.dax = t.tot_nz ? sat32(fsh(-pa)) : '0;
      t.day = t.tot_nz ? sat32(fsh(-pb)) : '0;
      pa = 96'(t.corx) * 96'($signed({1'b0, t.rat_b}));
      pb = 96'(t.cory) * 96'($signed({1'b0, t.rat_b}));
      t.dbx = t.tot_nz ? sat32(fsh(pa)) : '0;
      t.dby = t.tot_nz ? sat32(fsh(pb)) : '0;
      s[IMP_STAGE+1] <= t;

      // New velocities.
      t = s[IMP_STAGE+1];
      if (t.res && t.imp) begin
        t.vax = sat32(96'(t.vax) - 96'(qmul_f(t.ix, signed'({1'b0, t.ima}))));
        t.vay = sat32(96'(t.vay) - 96'(qmul_f(t.iy, signed'({1'b0, t.ima}))));
        t.vbx = sat32(96'(t.vbx) + 96'(qmul_f(t.ix, signed'({1'b0, t.imb}))));
        t.vby = sat32(96'(t.vby) + 96'(qmul_f(t.iy, signed'({1'b0, t.imb}))));
      end
      s[IMP_STAGE+2] <= t;
    end
  end

  assign den1 = (den0 == 0) ? 64'd1 : den0;
  assign tot1 = (tot0 == 0) ? 64'd1 : tot0;

  icr_div u_dj (.clk(clk), .en(adv), .num(num0), .den(den1), .quo(jq));
  icr_div u_da (.clk(clk), .en(adv), .num(man0), .den(tot1), .quo(raq));
  icr_div u_db (.clk(clk), .en(adv), .num(mbn0), .den(tot1), .quo(rbq));

  assign out_valid = vld[PIPE_DEPTH-1];
  assign new_vel_a = {s[PIPE_DEPTH-1].vay, s[PIPE_DEPTH-1].vax};
  assign new_vel_b = {s[PIPE_DEPTH-1].vby, s[PIPE_DEPTH-1].vbx};
  assign shift_a = s[PIPE_DEPTH-1].res ? {s[PIPE_DEPTH-1].day, s[PIPE_DEPTH-1].dax} : 64'd0;
  assign shift_b = s[PIPE_DEPTH-1].res ? {s[PIPE_DEPTH-1].dby, s[PIPE_DEPTH-1].dbx} : 64'd0;
  assign outcome = !s[PIPE_DEPTH-1].res ? OUT_SKIP :
                   (s[PIPE_DEPTH-1].imp ? OUT_IMPULSE : OUT_SHIFT);

endmodule

// File: src/icr_checker.sv
module icr_checker import icr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] outcome,
  input logic [63:0] shift_a,
  input logic [63:0] shift_b
);
`include "impulse_collision_resolver_assert.svh"

  `ICR_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(outcome), "held word changed")
  `ICR_ASSERT_IMP(a_code, clk, rst, out_valid, outcome != 2'd3, "bad outcome")
  `ICR_ASSERT_IMP(a_skip, clk, rst, out_valid && outcome == OUT_SKIP, shift_a == 0 && shift_b == 0, "skip with shift")
  `ICR_ASSERT_IMP(a_stall, clk, rst, in_stall, out_valid && out_stall, "stall without back pressure")

endmodule

bind impulse_collision_resolver icr_checker u_chk (.*);

// File: tb/tb_impulse_collision_resolver.sv
`timescale 1ns / 100ps

module tb_impulse_collision_resolver;
  import icr_pkg::*;

  typedef struct {
    logic [30:0] ma, mb, ima, imb;
    logic [63:0] va, vb, nrm;
    logic signed [31:0] pen;
    logic [16:0] ra, rb;
    logic [1:0] solid;
  } contact_t;

  typedef struct {
    logic [63:0] nva, nvb, sa, sb;
    outcome_t oc;
  } response_t;

  typedef struct {
    contact_t c;
    logic has_exp;
    response_t r;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [30:0] mass_a = '0, mass_b = '0, inv_mass_a = '0, inv_mass_b = '0;
  logic [63:0] vel_a = '0, vel_b = '0, contact_normal = '0;
  logic signed [31:0] penetration = '0;
  logic [16:0] restitution_a = '0, restitution_b = '0;
  logic [1:0] solid_flags = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [63:0] new_vel_a, new_vel_b, shift_a, shift_b;
  logic [1:0] outcome;

  impulse_collision_resolver dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mass_a(mass_a), .mass_b(mass_b), .inv_mass_a(inv_mass_a), .inv_mass_b(inv_mass_b),
    .vel_a(vel_a), .vel_b(vel_b), .contact_normal(contact_normal),
    .penetration(penetration), .restitution_a(restitution_a),
    .restitution_b(restitution_b), .solid_flags(solid_flags),
    .out_valid(out_valid), .out_stall(out_stall),
    .new_vel_a(new_vel_a), .new_vel_b(new_vel_b),
    .shift_a(shift_a), .shift_b(shift_b), .outcome(outcome)
  );

  always #5 clk = ~clk;

  logic [30:0] threshold = '0;
  response_t pending[$];
  int errors = 0;
  bit calm = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  function automatic longint qprod(longint a, longint b);
    return clamp32((a * b) >>> FRAC_BITS);
  endfunction

  function automatic logic [63:0] join_yx(longint y, longint x);
    logic [31:0] yy, xx;
    yy = y[31:0];
    xx = x[31:0];
    return {yy, xx};
  endfunction

  function automatic response_t resolve_contact(contact_t c, logic [30:0] thr);
    response_t r;
    longint vax, vay, vbx, vby, nx, ny, pen, rvx, rvy, p1, p2, speed, j, ix, iy;
    longint corx, cory, rat_a, rat_b, sax, say, sbx, sby;
    longint unsigned den, total, e, num;
    vax = longint'($signed(c.va[31:0])); vay = longint'($signed(c.va[63:32]));
    vbx = longint'($signed(c.vb[31:0])); vby = longint'($signed(c.vb[63:32]));
    nx = longint'($signed(c.nrm[31:0])); ny = longint'($signed(c.nrm[63:32]));
    pen = longint'(c.pen);
    sax = 0; say = 0; sbx = 0; sby = 0;
    r.oc = OUT_SKIP;
    if (pen > longint'(thr) && c.solid == 2'b11) begin
      rvx = clamp32(vbx - vax);
      rvy = clamp32(vby - vay);
      p1 = rvx * nx;
      p2 = rvy * ny;
      speed = clamp32((p1 >>> FRAC_BITS) + (p2 >>> FRAC_BITS) +
                      ((longint'(p1[FRAC_BITS-1:0]) + longint'(p2[FRAC_BITS-1:0]))
                       >>> FRAC_BITS));
      den = longint'(c.ima) + longint'(c.imb);
      total = longint'(c.ma) + longint'(c.mb);
      r.oc = OUT_SHIFT;
      if (speed < 0 && den != 0) begin
        e = (c.ra < c.rb) ? c.ra : c.rb;
        num = ((64'd1 << FRAC_BITS) + e) * longint'(-speed);
        j = clamp32(longint'(num / den));
        ix = qprod(nx, j);
        iy = qprod(ny, j);
        vax = clamp32(vax - qprod(ix, longint'(c.ima)));
        vay = clamp32(vay - qprod(iy, longint'(c.ima)));
        vbx = clamp32(vbx + qprod(ix, longint'(c.imb)));
        vby = clamp32(vby + qprod(iy, longint'(c.imb)));
        r.oc = OUT_IMPULSE;
      end
      corx = qprod(nx, pen);
      cory = qprod(ny, pen);
      if (total != 0) begin
        rat_a = longint'((longint'(c.ma) << FRAC_BITS) / total);
        rat_b = longint'((longint'(c.mb) << FRAC_BITS) / total);
        sax = clamp32((-(corx * rat_a)) >>> FRAC_BITS);
        say = clamp32((-(cory * rat_a)) >>> FRAC_BITS);
        sbx = clamp32((corx * rat_b) >>> FRAC_BITS);
        sby = clamp32((cory * rat_b) >>> FRAC_BITS);
      end
    end
    r.nva = join_yx(vay, vax);
    r.nvb = join_yx(vby, vbx);
    r.sa = join_yx(say, sax);
    r.sb = join_yx(sby, sbx);
    return r;
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h20000);
      3: return -$urandom_range(0, 32'h20000);
      4: return $urandom_range(0, 1) ? 32'h10000 : 32'hFFFF0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_u31();
    case ($urandom_range(0, 4))
      0: return 31'h7FFFFFFF;
      1: return '0;
      2: return 31'($urandom_range(1, 32'h40000));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    int k;
    c.ma = rand_u31(); c.mb = rand_u31();
    c.ima = rand_u31(); c.imb = rand_u31();
    c.va = {rand_q(), rand_q()};
    c.vb = {rand_q(), rand_q()};
    k = int'($urandom_range(0, 3));
    if (k == 0) c.nrm = {32'h0, 32'h10000};
    else if (k == 1) c.nrm = {32'hFFFF0000, 32'h0};
    else if (k == 2) c.nrm = {32'h0000B505, 32'hFFFF4AFB};
    else c.nrm = {rand_q(), rand_q()};
    c.pen = $urandom_range(0, 3) == 0 ? $signed(rand_q()) :
            $signed(32'($urandom_range(0, 32'h30000)));
    c.ra = $urandom_range(0, 9) == 0 ? 17'($urandom) : 17'($urandom_range(0, 32'h10000));
    c.rb = $urandom_range(0, 9) == 0 ? 17'($urandom) : 17'($urandom_range(0, 32'h10000));
    c.solid = $urandom_range(0, 4) == 0 ? 2'($urandom) : 2'b11;
    return c;
  endfunction

  function automatic contact_t mk(logic [30:0] ma, mb, ima, imb, logic [63:0] va, vb,
                                  nrm, logic signed [31:0] pen, logic [16:0] ra, rb,
                                  logic [1:0] solid);
    contact_t c;
    c.ma = ma; c.mb = mb; c.ima = ima; c.imb = imb;
    c.va = va; c.vb = vb; c.nrm = nrm; c.pen = pen;
    c.ra = ra; c.rb = rb; c.solid = solid;
    return c;
  endfunction

  task automatic write_threshold(logic [30:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    threshold = v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (pending.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 10) @(negedge clk);
  endtask

  task automatic send_contact(contact_t c);
    if (!calm) while ($urandom_range(0, 99) < 25) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    mass_a <= c.ma; mass_b <= c.mb; inv_mass_a <= c.ima; inv_mass_b <= c.imb;
    vel_a <= c.va; vel_b <= c.vb; contact_normal <= c.nrm;
    penetration <= c.pen; restitution_a <= c.ra; restitution_b <= c.rb;
    solid_flags <= c.solid;
    pending.push_back(resolve_contact(c, threshold));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_row(row_t w);
    response_t p;
    if (w.has_exp) begin
      p = resolve_contact(w.c, threshold);
      if (p.nva !== w.r.nva) begin
        $error("new_vel_a exp %h got %h", w.r.nva, p.nva); errors++;
      end
      if (p.nvb !== w.r.nvb) begin
        $error("new_vel_b exp %h got %h", w.r.nvb, p.nvb); errors++;
      end
      if (p.sa !== w.r.sa) begin
        $error("shift_a exp %h got %h", w.r.sa, p.sa); errors++;
      end
      if (p.sb !== w.r.sb) begin
        $error("shift_b exp %h got %h", w.r.sb, p.sb); errors++;
      end
      if (p.oc !== w.r.oc) begin
        $error("outcome exp %0d got %0d", w.r.oc, p.oc); errors++;
      end
    end
    send_contact(w.c);
  endtask

  always @(negedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 25);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("unexpected word out");
        errors++;
      end else begin
        response_t x;
        x = pending.pop_front();
        if (new_vel_a !== x.nva) begin
          $error("new_vel_a exp %h got %h", x.nva, new_vel_a); errors++;
        end
        if (new_vel_b !== x.nvb) begin
          $error("new_vel_b exp %h got %h", x.nvb, new_vel_b); errors++;
        end
        if (shift_a !== x.sa) begin
          $error("shift_a exp %h got %h", x.sa, shift_a); errors++;
        end
        if (shift_b !== x.sb) begin
          $error("shift_b exp %h got %h", x.sb, shift_b); errors++;
        end
        if (outcome !== x.oc) begin
          $error("outcome exp %0d got %0d", x.oc, outcome); errors++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("FAIL impulse_collision_resolver");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t w;
    logic [63:0] vz;
    vz = 64'h0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    w.has_exp = 1;
    w.c = mk(31'h10000, 31'h10000, 31'h10000, 31'h10000, {32'h1, 32'h2}, {32'h3, 32'h4},
             {32'h0, 32'h10000}, 32'sh10000, 17'h10000, 17'h10000, 2'b01);
    w.r.nva = {32'h1, 32'h2}; w.r.nvb = {32'h3, 32'h4}; w.r.sa = vz; w.r.sb = vz;
    w.r.oc = OUT_SKIP;
    rows.push_back(w);
    w.c.solid = 2'b10; rows.push_back(w);
    w.c.solid = 2'b00; rows.push_back(w);
    w.c.solid = 2'b11; w.c.pen = '0; rows.push_back(w);
    w.c.pen = 32'sh80000000; rows.push_back(w);
    w.c = mk('0, '0, '0, '0, vz, vz, {32'h0, 32'h10000}, 32'sh10000, '0, '0, 2'b11);
    w.r.nva = vz; w.r.nvb = vz; w.r.oc = OUT_SHIFT;
    rows.push_back(w);
    w.has_exp = 0;
    w.c = mk(31'h10000, 31'h10000, '0, '0, {32'h0, 32'h10000}, {32'h0, 32'hFFFF0000},
             {32'h0, 32'h10000}, 32'sh10000, 17'h1FFFF, '0, 2'b11);
    rows.push_back(w);
    w.c.ima = 31'h10000; w.c.imb = 31'h10000; rows.push_back(w);
    w.c.ra = 17'h1FFFF; w.c.rb = 17'h1FFFF; rows.push_back(w);
    w.c.va = {32'h0, 32'hFFFF0000}; w.c.vb = {32'h0, 32'h10000}; rows.push_back(w);
    w.c = mk(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
             {32'h7FFFFFFF, 32'h7FFFFFFF}, {32'h80000000, 32'h80000000},
             {32'h7FFFFFFF, 32'h7FFFFFFF}, 32'sh7FFFFFFF, 17'h1FFFF, 17'h1FFFF, 2'b11);
    rows.push_back(w);
    w.c.va = {32'h80000000, 32'h80000000}; w.c.vb = {32'h7FFFFFFF, 32'h7FFFFFFF};
    w.c.nrm = {32'h80000000, 32'h80000000}; rows.push_back(w);
    w.c.ima = 31'd1; w.c.imb = '0; w.c.ma = '0; rows.push_back(w);
    w.c.nrm = {32'h0000B505, 32'h0000B505}; w.c.mb = '0; w.c.ma = 31'h10000;
    rows.push_back(w);
    w.c = mk(31'h30000, 31'h10000, 31'h5555, 31'h10000, {32'h0, 32'h20000}, vz,
             {32'h0, 32'h10000}, 32'sh8000, 17'h8000, 17'h4000, 2'b11);
    rows.push_back(w);

    foreach (rows[i]) send_row(rows[i]);
    in_valid <= 0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_threshold(31'h7FFFFFFF);
        1: write_threshold(31'h8000);
        2: write_threshold(31'($urandom_range(0, 32'h20000)));
        default: write_threshold('0);
      endcase
      calm = (ph == 2);
      for (int n = 0; n < 360; n++) send_contact(rand_contact());
      in_valid <= 0;
      calm = 0;
      drain();
    end

    if (pending.size() != 0) begin
      $error("results missing: %0d", pending.size());
      errors++;
    end
    if (errors == 0) $display("PASS impulse_collision_resolver");
    else $display("FAIL impulse_collision_resolver");
    $finish;
  end
endmodule
